FILE: rtl/gedd_pkg.sv
// ============================================================================
// gedd_pkg : shared types and constants of the gray error-diffusion dither
// Fixed-point scales, luma weights, register map and the result record.
// ============================================================================
package gedd_pkg;

  // Default frame limits handed to the top level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Configuration register map
  localparam int CFG_DIM_W      = 11;
  localparam int APB_DW         = 32;
  localparam int PADDR_W        = 3;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_DIM_W-1:0] IMAGE_WIDTH_RST  = 11'd320;
  localparam logic [CFG_DIM_W-1:0] IMAGE_HEIGHT_RST = 11'd240;

  // Luma weights over 256, result kept in 1/16 units
  localparam int LUMA_W0   = 77;
  localparam int LUMA_W1   = 150;
  localparam int LUMA_W2   = 29;
  localparam int GRAY_W    = 12;
  localparam int FRAC_BITS = 4;

  // Threshold 128.0 and white level 255.0 in 1/16 units
  localparam int THRESHOLD   = 2048;
  localparam int WHITE_LEVEL = 4080;

  // Diffusion weights over 16
  localparam int SHARE_RIGHT = 7;
  localparam int SHARE_DOWN  = 5;
  localparam int SHARE_DL    = 3;

  // Stored error width
  localparam int ERR_W = 16;

  // Output queue
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_LW    = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic pixel_on;
    logic frame_end;
  } out_item_t;

endpackage

FILE: rtl/gedd_err_line.sv
// ============================================================================
// gedd_err_line : next-row error line store
// One-port-write, one-port-read synchronous RAM with a fill count that
// stands in for clearing, and same-cycle write forwarding.
// ============================================================================
module gedd_err_line #(
  parameter int DEPTH = gedd_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [AW-1:0]                      rd_addr,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [gedd_pkg::ERR_W-1:0]  wr_data,
  input  logic                               frame_clear,
  output logic signed [gedd_pkg::ERR_W-1:0]  rd_data
);

  localparam int FW = $clog2(DEPTH + 1);

  logic signed [gedd_pkg::ERR_W-1:0] mem [DEPTH];
  logic signed [gedd_pkg::ERR_W-1:0] rdata_r;
  logic signed [gedd_pkg::ERR_W-1:0] fwd_data_r;
  logic                              fwd_valid_r;
  logic [AW-1:0]                     rd_addr_r;
  logic [FW-1:0]                     fill_r;
  logic [FW-1:0]                     fill_nxt;
  logic [FW-1:0]                     wr_top;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      rd_addr_r  <= rd_addr;
      fwd_data_r <= wr_data;
    end
  end

  // Entries at or above the fill count were not written in this frame
  assign wr_top = FW'(wr_addr) + FW'(1);

  always_comb begin
    fill_nxt = fill_r;
    if (frame_clear) begin
      fill_nxt = '0;
    end else if (wr_en && (wr_top > fill_r)) begin
      fill_nxt = wr_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (rd_en) begin
        fwd_valid_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_valid_r) begin
      rd_data = fwd_data_r;
    end else if (FW'(rd_addr_r) < fill_r) begin
      rd_data = rdata_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

FILE: rtl/gedd_out_fifo.sv
// ============================================================================
// gedd_out_fifo : result queue
// Small register queue between the dither stage and the output channel.
// ============================================================================
module gedd_out_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  gedd_pkg::out_item_t                 push_item,
  input  logic                                out_ready,
  output logic                                out_valid,
  output gedd_pkg::out_item_t                 out_item,
  output logic [gedd_pkg::OUTQ_LW-1:0]        level
);

  gedd_pkg::out_item_t              entry [gedd_pkg::OUTQ_DEPTH];
  logic [gedd_pkg::OUTQ_PW-1:0]     wr_ptr_r;
  logic [gedd_pkg::OUTQ_PW-1:0]     rd_ptr_r;
  logic [gedd_pkg::OUTQ_LW-1:0]     level_r;
  logic                             pop;

  function automatic logic [gedd_pkg::OUTQ_PW-1:0] ptr_inc(
    input logic [gedd_pkg::OUTQ_PW-1:0] p
  );
    if (p == gedd_pkg::OUTQ_PW'(gedd_pkg::OUTQ_DEPTH - 1)) begin
      return '0;
    end
    return p + gedd_pkg::OUTQ_PW'(1);
  endfunction

  assign out_valid = (level_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = entry[rd_ptr_r];
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      level_r <= level_r + gedd_pkg::OUTQ_LW'(push) - gedd_pkg::OUTQ_LW'(pop);
    end
  end

endmodule

FILE: rtl/gray_error_diffusion_dither.sv
// ============================================================================
// gray_error_diffusion_dither : one-bit gray dither with error diffusion
// Converts three-channel pixels in raster order to gray, adds the diffused
// error and thresholds to black or white, spreading the error 7/5/3/1 by 16.
// ============================================================================
//
//  channel  ports                         handshake         direction
//  -------  ----------------------------  ----------------  ---------
//  input    in_chan0/1/2                  in_valid/ready    in
//  result   out_pixel_on, out_frame_end   out_valid/ready   out
//  config   psel/penable/pwrite/paddr...  APB, pready high  in
//
//  One request enters per cycle unless the input is held; the work stage
//  queues its result. The rate is set by the carry loop (right-neighbour
//  error feeding the next pixel's sum) and by the line store's single
//  write port: after a row end at a column other than zero, with a width of
//  one, the input waits so the held write can land. in_ready also drops
//  while the output queue and the work stage hold three results. Reset
//  needs no clearing pass: a fill count marks the line entries written in
//  the current frame, all others read as zero.
// ============================================================================
module gray_error_diffusion_dither #(
  parameter int MAX_WIDTH  = gedd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gedd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_chan0,
  input  logic [7:0]                        in_chan1,
  input  logic [7:0]                        in_chan2,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_pixel_on,
  output logic                              out_frame_end,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gedd_pkg::PADDR_W-1:0]      paddr,
  input  logic [gedd_pkg::APB_DW-1:0]       pwdata,
  output logic [gedd_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int MW  = (CW > RW) ? CW : RW;
  // Compare width: holds a clamped dimension and the raw register
  localparam int DW  = ((MW > gedd_pkg::CFG_DIM_W) ? MW : gedd_pkg::CFG_DIM_W) + 1;
  localparam int EW  = gedd_pkg::ERR_W;
  localparam int SW  = EW + 2;   // pixel sum and quantization error
  localparam int PW  = SW + 3;   // error times a share weight
  localparam int QW  = PW - gedd_pkg::FRAC_BITS;
  localparam int GSW = gedd_pkg::GRAY_W + gedd_pkg::FRAC_BITS;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  // Divide by 16, rounding toward zero
  function automatic logic signed [QW-1:0] div16_tz(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] biased;
    biased = x + (x[PW-1] ? PW'((1 << gedd_pkg::FRAC_BITS) - 1) : PW'(0));
    return biased[PW-1:gedd_pkg::FRAC_BITS];
  endfunction

  // Clip to the signed 16-bit range
  function automatic logic signed [EW-1:0] sat_err(input logic signed [EW+2:0] x);
    if (x > (EW+3)'((1 << (EW - 1)) - 1)) begin
      return EW'((1 << (EW - 1)) - 1);
    end
    if (x < -(EW+3)'(1 << (EW - 1))) begin
      return EW'(1 << (EW - 1));
    end
    return x[EW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [gedd_pkg::CFG_DIM_W-1:0] image_width_r;
  logic [gedd_pkg::CFG_DIM_W-1:0] image_height_r;
  logic                           cfg_wr;
  logic                           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= gedd_pkg::IMAGE_WIDTH_RST;
      image_height_r <= gedd_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        gedd_pkg::REG_IMAGE_WIDTH: begin
          image_width_r <= pwdata[gedd_pkg::CFG_DIM_W-1:0];
        end
        gedd_pkg::REG_IMAGE_HEIGHT: begin
          image_height_r <= pwdata[gedd_pkg::CFG_DIM_W-1:0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      gedd_pkg::REG_IMAGE_WIDTH: begin
        prdata = gedd_pkg::APB_DW'(image_width_r);
      end
      gedd_pkg::REG_IMAGE_HEIGHT: begin
        prdata = gedd_pkg::APB_DW'(image_height_r);
      end
    endcase
  end

  // Zero acts as one, oversize acts as the maximum
  logic [DW-1:0] width_raw, height_raw, width_eff, height_eff;

  assign width_raw  = DW'(image_width_r);
  assign height_raw = DW'(image_height_r);

  always_comb begin
    if (width_raw == '0) begin
      width_eff = DW'(1);
    end else if (width_raw > DW'(MAX_WIDTH)) begin
      width_eff = DW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    if (height_raw == '0) begin
      height_eff = DW'(1);
    end else if (height_raw > DW'(MAX_HEIGHT)) begin
      height_eff = DW'(MAX_HEIGHT);
    end else begin
      height_eff = height_raw;
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: position, gray, line store read
  // ---------------------------------------------------------------------
  logic [CW-1:0]  col_r;
  logic [RW-1:0]  row_r;
  logic           in_fire;
  logic           acc_last_col;
  logic           acc_last_row;
  logic [GSW-1:0] gray_sum;

  logic                          s1_valid_r;
  logic [CW-1:0]                 s1_col_r;
  logic                          s1_last_col_r;
  logic                          s1_last_row_r;
  logic [gedd_pkg::GRAY_W-1:0]   s1_gray_r;

  logic                          defer_valid_r;
  logic [CW-1:0]                 defer_addr_r;
  logic signed [EW-1:0]          defer_data_r;

  logic [gedd_pkg::OUTQ_LW-1:0]  q_level;
  logic                          queue_room;
  logic                          row_end_held;

  // A counter past a shrunk dimension counts as the last position
  assign acc_last_col = (DW'(col_r) + DW'(1)) >= width_eff;
  assign acc_last_row = (DW'(row_r) + DW'(1)) >= height_eff;

  assign gray_sum = GSW'(gedd_pkg::LUMA_W0) * GSW'(in_chan0)
                  + GSW'(gedd_pkg::LUMA_W1) * GSW'(in_chan1)
                  + GSW'(gedd_pkg::LUMA_W2) * GSW'(in_chan2);

  // Hold input while a row end will need the write port next cycle and a
  // one-pixel row would write column zero in that same cycle
  assign row_end_held = s1_valid_r && s1_last_col_r && (s1_col_r != '0) && !s1_last_row_r
                      && (width_eff == DW'(1));
  assign queue_room   = ((gedd_pkg::OUTQ_LW + 1)'(q_level) + (gedd_pkg::OUTQ_LW + 1)'(s1_valid_r))
                      < (gedd_pkg::OUTQ_LW + 1)'(gedd_pkg::OUTQ_DEPTH);
  assign in_ready     = queue_room && !row_end_held;
  assign in_fire      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      if (in_fire) begin
        if (acc_last_col) begin
          col_r <= '0;
          if (acc_last_row) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + RW'(1);
          end
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r      <= col_r;
      s1_last_col_r <= acc_last_col;
      s1_last_row_r <= acc_last_row;
      s1_gray_r     <= gray_sum[GSW-1:gedd_pkg::FRAC_BITS];
    end
  end

  // ---------------------------------------------------------------------
  // Work stage: sum, threshold, diffuse, write back
  // ---------------------------------------------------------------------
  logic signed [EW-1:0] line_rd_data;
  logic signed [EW-1:0] rc_r, dp0_r, dp1_r;
  logic signed [EW-1:0] rc_nxt, dp0_nxt, dp1_nxt;

  logic signed [SW-1:0] pix_sum;
  logic                 pix_on;
  logic signed [SW-1:0] q_err;
  logic signed [QW-1:0] share_right, share_down, share_dl, share_dr;
  logic signed [EW-1:0] dp_left, dp_here, rc_spread, pend_spread;
  logic                 col_nz;
  logic                 spread;
  logic                 frame_last;

  logic                 s1_wr_en;
  logic                 line_wr_en;
  logic [CW-1:0]        line_wr_addr;
  logic signed [EW-1:0] line_wr_data;

  assign col_nz     = (s1_col_r != '0);
  assign frame_last = s1_last_col_r && s1_last_row_r;
  assign spread     = !s1_last_row_r && !s1_last_col_r && col_nz;

  assign pix_sum = SW'($signed({1'b0, s1_gray_r})) + SW'(rc_r) + SW'(line_rd_data);
  assign pix_on  = pix_sum > SW'(gedd_pkg::THRESHOLD);
  assign q_err   = pix_on ? (pix_sum - SW'(gedd_pkg::WHITE_LEVEL)) : pix_sum;

  assign share_right = div16_tz(PW'(q_err) * PW'(gedd_pkg::SHARE_RIGHT));
  assign share_down  = div16_tz(PW'(q_err) * PW'(gedd_pkg::SHARE_DOWN));
  assign share_dl    = div16_tz(PW'(q_err) * PW'(gedd_pkg::SHARE_DL));
  assign share_dr    = div16_tz(PW'(q_err));

  always_comb begin
    if (spread) begin
      rc_spread   = sat_err((EW+3)'(share_right));
      dp_left     = sat_err((EW+3)'(dp0_r) + (EW+3)'(share_dl));
      dp_here     = sat_err((EW+3)'(dp1_r) + (EW+3)'(share_down));
      pend_spread = sat_err((EW+3)'(share_dr));
    end else begin
      rc_spread   = '0;
      dp_left     = dp0_r;
      dp_here     = dp1_r;
      pend_spread = '0;
    end
    // Drop the row's carries at its end
    if (s1_last_col_r) begin
      rc_nxt  = '0;
      dp0_nxt = '0;
      dp1_nxt = '0;
    end else begin
      rc_nxt  = rc_spread;
      dp0_nxt = dp_here;
      dp1_nxt = pend_spread;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r          <= '0;
      dp0_r         <= '0;
      dp1_r         <= '0;
      defer_valid_r <= 1'b0;
    end else begin
      if (s1_valid_r) begin
        rc_r  <= rc_nxt;
        dp0_r <= dp0_nxt;
        dp1_r <= dp1_nxt;
      end
      // Row end past column zero writes two entries: hold the second
      defer_valid_r <= s1_valid_r && s1_last_col_r && col_nz && !s1_last_row_r;
    end
  end

  always_ff @(posedge clk) begin
    defer_addr_r <= s1_col_r;
    defer_data_r <= dp_here;
  end

  // Completed column to the left, or column zero of a one-pixel row;
  // nothing at frame end since the line starts clear
  assign s1_wr_en = s1_valid_r && !frame_last && (col_nz || s1_last_col_r);

  always_comb begin
    line_wr_en = defer_valid_r || s1_wr_en;
    if (defer_valid_r) begin
      line_wr_addr = defer_addr_r;
      line_wr_data = defer_data_r;
    end else if (col_nz) begin
      line_wr_addr = s1_col_r - CW'(1);
      line_wr_data = dp_left;
    end else begin
      line_wr_addr = s1_col_r;
      line_wr_data = dp_here;
    end
  end

  gedd_err_line #(
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_fire),
    .rd_addr     (col_r),
    .wr_en       (line_wr_en),
    .wr_addr     (line_wr_addr),
    .wr_data     (line_wr_data),
    .frame_clear (s1_valid_r && frame_last),
    .rd_data     (line_rd_data)
  );

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  gedd_pkg::out_item_t res_item;
  gedd_pkg::out_item_t q_item;

  assign res_item.pixel_on  = pix_on;
  assign res_item.frame_end = frame_last;

  gedd_out_fifo u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_item (res_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (q_item),
    .level     (q_level)
  );

  assign out_pixel_on  = q_item.pixel_on;
  assign out_frame_end = q_item.frame_end;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The held row-end write never meets a write from the work stage
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    defer_valid_r |-> !s1_wr_en)
    else $error("line store write port claimed twice");

  // The work stage always finds room in the result queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (q_level < gedd_pkg::OUTQ_LW'(gedd_pkg::OUTQ_DEPTH)))
    else $error("result queue overrun");

  // A row end leaves no carried error behind
  a_row_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_col_r) |=> (rc_r == '0 && dp0_r == '0 && dp1_r == '0))
    else $error("carry state not cleared at row end");

endmodule

FILE: tb/sv/tb.sv
// ============================================================================
// tb : self-checking bench for the gray error-diffusion dither
// Streams pixels through the valid/ready input, mirrors the dither in a
// cycle-free predictor (gray conversion, threshold, 7/5/3/1 error spread,
// frame bookkeeping) and checks every result in order. Frame sizes are set
// over the APB port, read back, and changed while the block is idle.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gedd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int MAX_W        = MAX_WIDTH_DEF;
  localparam int MAX_H        = MAX_HEIGHT_DEF;
  localparam int IDLE_PCT     = 29;
  localparam int SMALL_ITEMS  = 1550;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } rgb_t;

  // Content styles of a random pixel run
  typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_NEAR_MID, MIX_FLAT} mix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_chan0 = '0;
  logic [7:0] in_chan1 = '0;
  logic [7:0] in_chan2 = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic out_pixel_on;
  logic out_frame_end;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [APB_DW-1:0]  pwdata  = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  // Requests waiting for the driver, results waiting for the checker
  rgb_t      pixel_q[$];
  out_item_t expected_pixels[$];

  int error_count = 0;
  bit gaps_on     = 1'b1;

  // Predictor state: register mirror, error line and diffusion pipeline
  logic [CFG_DIM_W-1:0]    width_cfg;
  logic [CFG_DIM_W-1:0]    height_cfg;
  logic signed [ERR_W-1:0] err_line [MAX_W];
  logic signed [ERR_W-1:0] carry_right;
  logic signed [ERR_W-1:0] diag_acc [2];
  int                      col_pos;
  int                      row_pos;

  gray_error_diffusion_dither uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_chan0      (in_chan0),
    .in_chan1      (in_chan1),
    .in_chan2      (in_chan2),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_on  (out_pixel_on),
    .out_frame_end (out_frame_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int sat16(int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // Zero acts as one, oversize acts as the build limit
  function automatic int clamp_dim(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void clear_frame();
    foreach (err_line[i]) err_line[i] = '0;
    carry_right = '0;
    diag_acc[0] = '0;
    diag_acc[1] = '0;
    col_pos     = 0;
    row_pos     = 0;
  endfunction

  function automatic out_item_t dither_pixel(rgb_t px);
    int        w, h, col, gray, level, err, below_right;
    bit        last_col, last_row, spread;
    out_item_t res;
    w        = clamp_dim(int'(width_cfg), MAX_W);
    h        = clamp_dim(int'(height_cfg), MAX_H);
    col      = col_pos;
    // A counter past a shrunken size counts as sitting on the last position
    last_col = (col + 1 >= w);
    last_row = (row_pos + 1 >= h);
    gray  = (LUMA_W0 * int'(px.c0) + LUMA_W1 * int'(px.c1) + LUMA_W2 * int'(px.c2))
            >> FRAC_BITS;
    level = gray + int'(carry_right) + int'(err_line[col]);
    res.pixel_on = (level > THRESHOLD);
    err          = res.pixel_on ? level - WHITE_LEVEL : level;
    // Spread only with a left, right and lower neighbour in the frame
    spread = !last_row && !last_col && (col >= 1);
    if (spread) begin
      carry_right = sat16((err * SHARE_RIGHT) / (1 << FRAC_BITS));
      diag_acc[0] = sat16(int'(diag_acc[0]) + (err * SHARE_DL) / (1 << FRAC_BITS));
      diag_acc[1] = sat16(int'(diag_acc[1]) + (err * SHARE_DOWN) / (1 << FRAC_BITS));
      below_right = sat16(err / (1 << FRAC_BITS));
    end else begin
      carry_right = '0;
      below_right = 0;
    end
    // The column to the left has collected all its next-row shares
    if (col >= 1) err_line[col - 1] = diag_acc[0];
    diag_acc[0] = diag_acc[1];
    diag_acc[1] = below_right;
    res.frame_end = 1'b0;
    if (last_col) begin
      err_line[col] = diag_acc[0];
      carry_right   = '0;
      diag_acc[0]   = '0;
      diag_acc[1]   = '0;
      col_pos       = 0;
      if (last_row) begin
        res.frame_end = 1'b1;
        clear_frame();
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col + 1;
    end
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      if (error_count < REPORT_LIMIT)
        $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: pop the next pixel whenever the slot is free, idle at
  // random, hold valid and payload until the request is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    rgb_t px;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < IDLE_PCT)) begin
        px = pixel_q.pop_front();
        in_valid <= 1'b1;
        in_chan0 <= px.c0;
        in_chan1 <= px.c1;
        in_chan2 <= px.c2;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random back-pressure, plus a long hold-off after 400
  // results and every 900 after that so the output queue fills and the input stalls
  // --------------------------------------------------------------------------
  int results_taken;
  int hold_left;
  int hold_mark;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready     <= 1'b0;
      results_taken <= 0;
      hold_left     <= 0;
      hold_mark     <= 400;
    end else begin
      if (out_valid && out_ready) results_taken <= results_taken + 1;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (results_taken >= hold_mark) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_mark <= hold_mark + 900;
      end else begin
        out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every taken request, compare every taken result
  // against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_pixels.push_back(dither_pixel('{in_chan0, in_chan1, in_chan2}));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          if (error_count < REPORT_LIMIT)
            $error("result with no request pending: pixel_on %0b frame_end %0b",
                   out_pixel_on, out_frame_end);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_on", want.pixel_on, out_pixel_on);
          check_field("frame_end", want.frame_end, out_frame_end);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one size register, update the mirror, then read it back
  task automatic reg_write(logic idx, logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_cfg = data[CFG_DIM_W-1:0];
    else height_cfg = data[CFG_DIM_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH)
      check_field("image_width", width_cfg, prdata[CFG_DIM_W-1:0]);
    else
      check_field("image_height", height_cfg, prdata[CFG_DIM_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every queued request is taken and every result is back
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
  endtask

  function automatic rgb_t make_pixel(mix_t mix, rgb_t flat_px);
    rgb_t px;
    int   mid;
    case (mix)
      MIX_EXTREME: begin
        px.c0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.c1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.c2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      MIX_NEAR_MID: begin
        // Hover around the threshold so carried error decides the bit
        mid   = $urandom_range(112, 144);
        px.c0 = 8'(mid + $urandom_range(0, 6) - 3);
        px.c1 = 8'(mid + $urandom_range(0, 6) - 3);
        px.c2 = 8'(mid + $urandom_range(0, 6) - 3);
      end
      MIX_FLAT: begin
        px = ($urandom_range(0, 7) == 0) ? rgb_t'($urandom) : flat_px;
      end
      default: px = rgb_t'($urandom);
    endcase
    return px;
  endfunction

  task automatic queue_pixels(int count, mix_t mix);
    rgb_t flat_px;
    flat_px = rgb_t'($urandom);
    repeat (count) pixel_q.push_back(make_pixel(mix, flat_px));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  rgb_t directed_px [12] = '{
    '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00},
    '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF}, '{8'd128, 8'd128, 8'd128},
    '{8'd129, 8'd129, 8'd129}, '{8'hAA, 8'h55, 8'hAA}, '{8'h55, 8'hAA, 8'h55},
    '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'd127, 8'd127, 8'd127}
  };

  initial begin
    int   phase, small_sent, w_raw, h_raw, ew, eh, count;
    mix_t mix;

    width_cfg  = IMAGE_WIDTH_RST;
    height_cfg = IMAGE_HEIGHT_RST;
    clear_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one 4x3 frame of black, white, single channels, the exact
    // threshold and alternating bit patterns
    reg_write(REG_IMAGE_WIDTH, 4);
    reg_write(REG_IMAGE_HEIGHT, 3);
    foreach (directed_px[i]) pixel_q.push_back(directed_px[i]);
    drain();

    // Zero sizes behave as 1x1: every pixel closes a frame
    reg_write(REG_IMAGE_WIDTH, 0);
    reg_write(REG_IMAGE_HEIGHT, 0);
    queue_pixels(2, MIX_UNIFORM);
    drain();

    // Oversize height, then shrink the width mid-row and the height
    // mid-frame: the counters past the new end close the row and the frame
    reg_write(REG_IMAGE_WIDTH, 5);
    reg_write(REG_IMAGE_HEIGHT, 2047);
    queue_pixels(7, MIX_NEAR_MID);
    drain();
    reg_write(REG_IMAGE_WIDTH, 2);
    queue_pixels(2, MIX_NEAR_MID);
    drain();
    reg_write(REG_IMAGE_HEIGHT, 1);
    queue_pixels(2, MIX_UNIFORM);
    drain();

    // Random phases: mostly small frames, whole and partial, with one
    // full-width pass; no idling on either side for phases 4 to 7
    phase      = 0;
    small_sent = 0;
    while (small_sent < SMALL_ITEMS) begin
      gaps_on = (phase < 4 || phase > 7);
      mix     = mix_t'($urandom_range(0, 3));
      if (phase == 10) begin
        // Widest row: fill the whole error line, then spill into row two
        reg_write(REG_IMAGE_WIDTH, 2047);
        reg_write(REG_IMAGE_HEIGHT, 2);
        queue_pixels(MAX_W + $urandom_range(8, 40), mix);
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       w_raw = 0;
            1:       w_raw = 1;
            default: w_raw = $urandom_range(2, 12);
          endcase
          case ($urandom_range(0, 9))
            0:       h_raw = 0;
            1:       h_raw = 1;
            2:       h_raw = $urandom_range(MAX_H + 1, 2047);
            default: h_raw = $urandom_range(2, 6);
          endcase
          reg_write(REG_IMAGE_WIDTH, w_raw);
          reg_write(REG_IMAGE_HEIGHT, h_raw);
        end
        ew = clamp_dim(int'(width_cfg), MAX_W);
        eh = clamp_dim(int'(height_cfg), MAX_H);
        if (eh == MAX_H || ew * eh > 200) begin
          count = $urandom_range(5, 40);
        end else begin
          count = $urandom_range(1, 3) * ew * eh;
          // Leave a partial frame now and then for the next size change
          if ($urandom_range(0, 2) == 0) count += $urandom_range(1, ew * eh);
        end
        queue_pixels(count, mix);
        small_sent += count;
      end
      drain();
      phase++;
    end

    // Give a stray late result the chance to show up
    gaps_on = 1'b1;
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: gray_error_diffusion_dither.f
rtl/gedd_pkg.sv
rtl/gedd_err_line.sv
rtl/gedd_out_fifo.sv
rtl/gray_error_diffusion_dither.sv
tb/sv/tb.sv
